### rtl/core/cpx_pkg.sv
// package with shared types, codes and helpers for the cascade position pid
`timescale 1ns / 1ps
`default_nettype none
package cpx_pkg;

  // fixed widths of internal values
  localparam int unsigned ErrW  = 17;  // position error, Q.4
  localparam int unsigned EdW   = 18;  // error difference
  localparam int unsigned IntW  = 17;  // clamped integral, |I| <= 65535
  localparam int unsigned VelW  = 22;  // velocity, position diff times 20
  localparam int unsigned VspW  = 27;  // outer loop output
  localparam int unsigned SpdW  = 29;  // speed error
  localparam int unsigned SdW   = 30;  // speed error difference
  localparam int unsigned OpW   = 30;  // multiplier operand
  localparam int unsigned AccW  = 48;  // product sum
  localparam int unsigned CmdW  = 12;  // output command
  localparam logic signed [AccW-1:0] OutLimit = AccW'(1280);

  // configuration register indexes
  localparam logic [2:0] CfgOuterX = 3'd0;
  localparam logic [2:0] CfgOuterY = 3'd1;
  localparam logic [2:0] CfgInnerX = 3'd2;
  localparam logic [2:0] CfgInnerY = 3'd3;
  localparam logic [2:0] CfgTarget = 3'd4;
  localparam logic [2:0] CfgMode   = 3'd5;
  localparam logic [2:0] CfgVar    = 3'd6;
  localparam logic [2:0] CfgMinH   = 3'd7;

  // hold modes
  localparam logic [1:0] ModeFree  = 2'd0;
  localparam logic [1:0] ModeHold  = 2'd1;
  localparam logic [1:0] ModeTrack = 2'd2;
  localparam logic [1:0] ModeKeep  = 2'd3;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_FIN
  } seq_state_e;

  typedef enum logic [3:0] {
    ST_ERR,
    ST_MKP,
    ST_MKI,
    ST_MKD,
    ST_MSUM,
    ST_SPD,
    ST_INT,
    ST_IKP,
    ST_IKI,
    ST_IKD,
    ST_ISUM,
    ST_OUT
  } step_e;

  typedef struct packed {
    logic mul_en;
    logic acc_ld;
    logic acc_add;
  } mac_ctl_t;

  typedef struct packed {
    logic  busy;
    logic  run;
    step_e step;
    logic  axis;
    logic  fin;
  } dp_ctl_t;

  // symmetric clamp of an integral sum to +-lim
  function automatic logic signed [IntW-1:0] clamp_int(input logic signed [SdW-1:0] v,
                                                       input logic [15:0] lim);
    logic signed [SdW-1:0] l;
    l = $signed(SdW'(lim));
    if (v > l) return IntW'(l);
    else if (v < -l) return IntW'(-l);
    else return IntW'(v);
  endfunction

endpackage
`default_nettype wire

### rtl/core/cascade_position_pid_xy.sv
// top level: config registers, per-axis loop state and output register
// a hold run takes each axis through 12 steps on the one shared multiplier and
//   accumulator set; otherwise the steps are skipped and the output register is set
// the next transaction is taken once the result sits in the output register
// reset clears config (min height 40), all loop state and last outputs to zero
`timescale 1ns / 1ps
`default_nettype none
module cascade_position_pid_xy (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [63:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic signed [15:0]  pos_x_i,
  input  wire logic signed [15:0]  pos_y_i,
  input  wire logic [11:0]         altitude_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic signed [11:0]  pitch_cmd_o,
  output      logic signed [11:0]  roll_cmd_o
);
  import cpx_pkg::*;

  // configuration
  logic [63:0] outer_q [2];
  logic [63:0] inner_q [2];
  logic [31:0] target_q;
  logic [1:0]  mode_q;
  logic        variant_q;
  logic [11:0] min_h_q;

  // loop state
  logic signed [IntW-1:0] io_q [2];
  logic signed [IntW-1:0] ii_q [2];
  logic signed [ErrW-1:0] pe_q [2];
  logic signed [SpdW-1:0] ps_q [2];
  logic signed [15:0]     pp_q [2];
  logic signed [CmdW-1:0] res_q [2];

  // working registers
  logic signed [15:0]     posx_q, posy_q;
  logic                   keep_q;
  logic signed [ErrW-1:0] e_q;
  logic signed [EdW-1:0]  ed_q;
  logic signed [IntW-1:0] icur_q;
  logic signed [VelW-1:0] vel_q;
  logic signed [SpdW-1:0] s_q;
  logic signed [SdW-1:0]  sd_q;
  logic signed [CmdW-1:0] pitch_q, roll_q;
  logic                   out_valid_q;

  mac_ctl_t               mac_ctl;
  dp_ctl_t                dp;
  logic                   start_run;
  logic                   in_acc;
  logic                   out_free;
  logic                   ax;
  logic signed [AccW-1:0] acc;
  logic [15:0]            gain;
  logic signed [OpW-1:0]  opnd;
  logic [63:0]            ot, it;
  logic signed [15:0]     pos, tgt;
  logic signed [ErrW-1:0] e_w, dpos_w;
  logic signed [VelW-1:0] vel_w;
  logic signed [VspW-1:0] vsp_w;
  logic signed [AccW-1:0] sh_w;
  logic signed [CmdW-1:0] out_w;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign start_run   = (mode_q == ModeHold) && (altitude_i > min_h_q);
  assign out_free    = !out_valid_q || out_ready_i;

  cpx_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .start_run_i (start_run),
    .out_free_i  (out_free),
    .in_ready_o  (in_ready_o),
    .mac_ctl_o   (mac_ctl),
    .dp_ctl_o    (dp)
  );

  cpx_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .gain_i (gain),
    .opnd_i (opnd),
    .acc_o  (acc)
  );

  // per axis selections
  assign ax     = dp.axis;
  assign ot     = outer_q[ax];
  assign it     = inner_q[ax];
  assign pos    = ax ? posy_q : posx_q;
  assign tgt    = ax ? $signed(target_q[31:16]) : $signed(target_q[15:0]);
  assign e_w    = ErrW'(tgt) - ErrW'(pos);
  assign dpos_w = ErrW'(pos) - ErrW'(pp_q[ax]);
  assign vel_w  = (VelW'(dpos_w) <<< 4) + (VelW'(dpos_w) <<< 2);
  assign vsp_w  = acc[VspW+7:8];
  assign sh_w   = acc >>> 4;

  always_comb begin
    if (sh_w > OutLimit) out_w = CmdW'(OutLimit);
    else if (sh_w < -OutLimit) out_w = CmdW'(-OutLimit);
    else out_w = CmdW'(sh_w);
  end

  // operand select for the multiplier
  always_comb begin
    gain = '0;
    opnd = '0;
    unique case (dp.step)
      ST_MKP: begin gain = ot[15:0];  opnd = OpW'(e_q);    end
      ST_MKI: begin gain = ot[31:16]; opnd = OpW'(icur_q); end
      ST_MKD: begin gain = ot[47:32]; opnd = OpW'(ed_q);   end
      ST_IKP: begin gain = it[15:0];  opnd = OpW'(s_q);    end
      ST_IKI: begin gain = it[31:16]; opnd = OpW'(icur_q); end
      ST_IKD: begin gain = it[47:32]; opnd = OpW'(sd_q);   end
      default: begin gain = '0; opnd = '0; end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q[0] <= '0;
      outer_q[1] <= '0;
      inner_q[0] <= '0;
      inner_q[1] <= '0;
      target_q   <= '0;
      mode_q     <= ModeFree;
      variant_q  <= 1'b0;
      min_h_q    <= 12'd40;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOuterX: outer_q[0] <= cfg_data_i;
        CfgOuterY: outer_q[1] <= cfg_data_i;
        CfgInnerX: inner_q[0] <= cfg_data_i;
        CfgInnerY: inner_q[1] <= cfg_data_i;
        CfgTarget: target_q   <= cfg_data_i[31:0];
        CfgMode:   mode_q     <= cfg_data_i[1:0];
        CfgVar:    variant_q  <= cfg_data_i[0];
        CfgMinH:   min_h_q    <= cfg_data_i[11:0];
        default:   min_h_q    <= min_h_q;
      endcase
    end
  end

  // loop datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 2; a++) begin
        io_q[a]  <= '0;
        ii_q[a]  <= '0;
        pe_q[a]  <= '0;
        ps_q[a]  <= '0;
        pp_q[a]  <= '0;
        res_q[a] <= '0;
      end
      posx_q <= '0;
      posy_q <= '0;
      keep_q <= 1'b0;
      e_q    <= '0;
      ed_q   <= '0;
      icur_q <= '0;
      vel_q  <= '0;
      s_q    <= '0;
      sd_q   <= '0;
    end else begin
      if (in_acc) begin
        posx_q <= pos_x_i;
        posy_q <= pos_y_i;
        keep_q <= (mode_q == ModeKeep);
      end
      if (dp.busy) begin
        unique case (dp.step)
          ST_ERR: begin
            e_q      <= e_w;
            ed_q     <= EdW'(e_w) - EdW'(pe_q[ax]);
            pe_q[ax] <= e_w;
            icur_q   <= clamp_int(SdW'(io_q[ax]) + SdW'(e_w), ot[63:48]);
            io_q[ax] <= clamp_int(SdW'(io_q[ax]) + SdW'(e_w), ot[63:48]);
            vel_q    <= vel_w;
            pp_q[ax] <= pos;
          end
          ST_SPD: begin
            s_q <= variant_q ? SpdW'(vsp_w) + SpdW'(vel_q) : SpdW'(vsp_w) - SpdW'(vel_q);
          end
          ST_INT: begin
            sd_q     <= SdW'(s_q) - SdW'(ps_q[ax]);
            ps_q[ax] <= s_q;
            icur_q   <= clamp_int(SdW'(ii_q[ax]) + SdW'(s_q), it[63:48]);
            ii_q[ax] <= clamp_int(SdW'(ii_q[ax]) + SdW'(s_q), it[63:48]);
          end
          ST_OUT: res_q[ax] <= out_w;
          default: s_q <= s_q;
        endcase
      end
    end
  end

  // output register holds the last outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pitch_q     <= '0;
      roll_q      <= '0;
    end else begin
      if (dp.fin) begin
        out_valid_q <= 1'b1;
        if (dp.run) begin
          pitch_q <= variant_q ? res_q[1] : res_q[0];
          roll_q  <= variant_q ? res_q[0] : res_q[1];
        end else if (!keep_q) begin
          pitch_q <= '0;
          roll_q  <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pitch_cmd_o = pitch_q;
  assign roll_cmd_o  = roll_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted transaction did not make the block busy");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_cmd_o <= 12'sd1280) && (pitch_cmd_o >= -12'sd1280))
    else $error("pitch command out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (roll_cmd_o <= 12'sd1280) && (roll_cmd_o >= -12'sd1280))
    else $error("roll command out of range");

  a_no_run_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !dp.busy && !dp.fin)
    else $error("datapath active while idle");
endmodule
`default_nettype wire

### rtl/core/cpx_mac.sv
// shared multiply-accumulate unit: gain times operand, registered product and sum
`timescale 1ns / 1ps
`default_nettype none
module cpx_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire cpx_pkg::mac_ctl_t                   ctl_i,
  input  wire logic [15:0]                         gain_i,
  input  wire logic signed [cpx_pkg::OpW-1:0]      opnd_i,
  output      logic signed [cpx_pkg::AccW-1:0]     acc_o
);
  import cpx_pkg::*;

  logic signed [OpW+16:0]  prod_d, prod_q;
  logic signed [AccW-1:0]  acc_d, acc_q;

  // multiply stage
  assign prod_d = $signed({1'b0, gain_i}) * opnd_i;

  // accumulate stage
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_ld) begin
      acc_d = AccW'(prod_q);
    end else if (ctl_i.acc_add) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctl_i.mul_en) prod_q <= prod_d;
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

### rtl/core/cpx_seq.sv
// sequencer stepping both axes through the shared multiply-accumulate unit
`timescale 1ns / 1ps
`default_nettype none
module cpx_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               start_run_i,
  input  wire logic               out_free_i,
  output      logic               in_ready_o,
  output      cpx_pkg::mac_ctl_t  mac_ctl_o,
  output      cpx_pkg::dp_ctl_t   dp_ctl_o
);
  import cpx_pkg::*;

  seq_state_e state_d, state_q;
  step_e      step_d, step_q;
  logic       axis_d, axis_q;
  logic       run_d, run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      step_q  <= ST_ERR;
      axis_q  <= 1'b0;
      run_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
      run_q   <= run_d;
    end
  end

  // next state and step
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    run_d   = run_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (in_valid_i) begin
          run_d  = start_run_i;
          step_d = ST_ERR;
          axis_d = 1'b0;
          state_d = start_run_i ? SQ_RUN : SQ_FIN;
        end
      end
      SQ_RUN: begin
        if (step_q == ST_OUT) begin
          step_d = ST_ERR;
          if (axis_q) begin
            state_d = SQ_FIN;
          end else begin
            axis_d = 1'b1;
          end
        end else begin
          step_d = step_e'(step_q + 4'd1);
        end
      end
      SQ_FIN: begin
        if (out_free_i) state_d = SQ_IDLE;
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // unit controls decoded from the step
  always_comb begin
    mac_ctl_o = '0;
    if (state_q == SQ_RUN) begin
      unique case (step_q)
        ST_MKP, ST_IKP: mac_ctl_o.mul_en = 1'b1;
        ST_MKI, ST_IKI: begin
          mac_ctl_o.mul_en = 1'b1;
          mac_ctl_o.acc_ld = 1'b1;
        end
        ST_MKD, ST_IKD: begin
          mac_ctl_o.mul_en  = 1'b1;
          mac_ctl_o.acc_add = 1'b1;
        end
        ST_MSUM, ST_ISUM: mac_ctl_o.acc_add = 1'b1;
        default: mac_ctl_o = '0;
      endcase
    end
  end

  assign in_ready_o     = (state_q == SQ_IDLE);
  assign dp_ctl_o.busy  = (state_q == SQ_RUN);
  assign dp_ctl_o.run   = run_q;
  assign dp_ctl_o.step  = step_q;
  assign dp_ctl_o.axis  = axis_q;
  assign dp_ctl_o.fin   = (state_q == SQ_FIN) && out_free_i;
endmodule
`default_nettype wire

### verif/tb.sv
// testbench for the two-axis cascade position/velocity pid
`timescale 1ns / 1ps
module tb;
  import cpx_pkg::*;

  typedef struct packed {
    logic signed [11:0] pitch;
    logic signed [11:0] roll;
  } cmd_t;

  localparam int unsigned StallLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [11:0] altitude = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [11:0] pitch_cmd;
  logic signed [11:0] roll_cmd;

  always #5 clk_i = ~clk_i;

  cascade_position_pid_xy i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .altitude_i  (altitude),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pitch_cmd_o (pitch_cmd),
    .roll_cmd_o  (roll_cmd)
  );

  // predictor copy of the configuration
  logic [63:0] outer_k[2];
  logic [63:0] inner_k[2];
  logic [31:0] setpoint;
  logic [1:0]  hold_mode;
  logic        variant;
  logic [11:0] min_h;

  // predictor copy of the loop state
  longint outer_acc[2], inner_acc[2], last_err[2], last_spd[2], last_pos[2];
  longint last_cmd[2];

  cmd_t   cmd_q[$];
  int     n_err, n_items, n_results, n_cfg, n_hold;
  bit     no_gaps;

  function automatic longint sat32(longint v);
    if (v > 64'sh7fffffff) return 64'sh7fffffff;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one axis of the cascade, updates the axis state
  function automatic longint pid_axis(int a, longint pos, longint tgt, bit added);
    longint kp, ki, kd, lim, e, integ, acc, vsp, vel, s;
    kp = longint'(outer_k[a][15:0]);
    ki = longint'(outer_k[a][31:16]);
    kd = longint'(outer_k[a][47:32]);
    lim = longint'(outer_k[a][63:48]);
    e = tgt - pos;
    integ = clamp_sym(sat32(outer_acc[a] + e), lim);
    acc = kp * e + ki * integ + kd * (e - last_err[a]);
    vsp = sat32(acc >>> 8);
    outer_acc[a] = integ;
    last_err[a] = e;
    vel = (pos - last_pos[a]) * 20;
    last_pos[a] = pos;
    s = sat32(added ? vsp + vel : vsp - vel);
    kp = longint'(inner_k[a][15:0]);
    ki = longint'(inner_k[a][31:16]);
    kd = longint'(inner_k[a][47:32]);
    lim = longint'(inner_k[a][63:48]);
    integ = clamp_sym(sat32(inner_acc[a] + s), lim);
    acc = kp * s + ki * integ + kd * (s - last_spd[a]);
    inner_acc[a] = integ;
    last_spd[a] = s;
    return clamp_sym(acc >>> 4, 1280);
  endfunction

  // expected pitch/roll for one position sample
  function automatic cmd_t predict_cmd(logic signed [15:0] px, logic signed [15:0] py,
                                       logic [11:0] alt);
    longint ox, oy;
    cmd_t c;
    if (hold_mode == ModeHold && alt > min_h) begin
      ox = pid_axis(0, px, longint'($signed(setpoint[15:0])), variant);
      oy = pid_axis(1, py, longint'($signed(setpoint[31:16])), variant);
      last_cmd[0] = variant ? oy : ox;
      last_cmd[1] = variant ? ox : oy;
      n_hold++;
    end else if (hold_mode != ModeKeep) begin
      last_cmd[0] = 0;
      last_cmd[1] = 0;
    end
    c.pitch = last_cmd[0][11:0];
    c.roll = last_cmd[1][11:0];
    return c;
  endfunction

  // register write, model updated on the transaction
  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    // drain the block first so no transaction in flight sees a changed setup
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CfgOuterX: outer_k[0] = data;
      CfgOuterY: outer_k[1] = data;
      CfgInnerX: inner_k[0] = data;
      CfgInnerY: inner_k[1] = data;
      CfgTarget: setpoint = data[31:0];
      CfgMode:   hold_mode = data[1:0];
      CfgVar:    variant = data[0];
      default:   min_h = data[11:0];
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // one position sample; valid stays up for a following transaction
  task automatic send_sample(logic signed [15:0] px, logic signed [15:0] py, logic [11:0] alt);
    in_valid <= 1'b1;
    pos_x <= px;
    pos_y <= py;
    altitude <= alt;
    do @(posedge clk_i); while (!in_ready);
    cmd_q.push_back(predict_cmd(px, py, alt));
    n_items++;
  endtask

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // wait until every result is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic load_gains(logic [63:0] ox, logic [63:0] oy, logic [63:0] ix,
                            logic [63:0] iy);
    cfg_write(CfgOuterX, ox);
    cfg_write(CfgOuterY, oy);
    cfg_write(CfgInnerX, ix);
    cfg_write(CfgInnerY, iy);
  endtask

  // reset values: zero gains, free mode
  task automatic test_reset_state();
    send_sample(16'sh7fff, -16'sh8000, 12'd4095);
    send_sample(16'sd0, 16'sd0, 12'd0);
    wait_idle();
  endtask

  // hold mode at the field extremes and the height threshold
  task automatic test_hold_extremes();
    load_gains(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
               64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    cfg_write(CfgTarget, 64'h8000_7fff);
    cfg_write(CfgMode, 64'(ModeHold));
    cfg_write(CfgVar, 64'd0);
    cfg_write(CfgMinH, 64'd40);
    send_sample(-16'sh8000, 16'sh7fff, 12'd4095);
    send_sample(16'sh7fff, -16'sh8000, 12'd41);
    send_sample(16'sh7fff, -16'sh8000, 12'd40);
    send_sample(16'sd0, 16'sd0, 12'd100);
    wait_idle();
    // zero integral limits, moderate gains
    load_gains(64'h0000_0100_0080_0200, 64'h0000_0040_0100_0080,
               64'h0000_0010_0020_0030, 64'h0000_0008_0010_0020);
    cfg_write(CfgTarget, 64'h0020_ffe0);
    send_sample(16'sd5, -16'sd5, 12'd200);
    send_sample(16'sd10, -16'sd12, 12'd200);
    cfg_write(CfgMinH, 64'd0);
    send_sample(16'sd1, 16'sd1, 12'd0);
    send_sample(16'sd1, 16'sd1, 12'd1);
    cfg_write(CfgMinH, 64'd4095);
    send_sample(16'sd2, 16'sd3, 12'd4095);
    wait_idle();
  endtask

  // free, track and keep modes, and the swapped variant
  task automatic test_modes();
    load_gains(64'h0200_0100_0080_0400, 64'h0200_0100_0080_0400,
               64'h0400_0010_0008_0020, 64'h0400_0010_0008_0020);
    cfg_write(CfgMinH, 64'd40);
    cfg_write(CfgMode, 64'(ModeHold));
    send_sample(16'sd30, -16'sd40, 12'd300);
    cfg_write(CfgMode, 64'(ModeKeep));
    send_sample(16'sd0, 16'sd0, 12'd300);
    send_sample(16'sd9, 16'sd9, 12'd0);
    cfg_write(CfgMode, 64'(ModeTrack));
    send_sample(16'sd30, 16'sd30, 12'd300);
    cfg_write(CfgMode, 64'(ModeFree));
    send_sample(16'sd30, 16'sd30, 12'd300);
    // resume hold with the stored previous position
    cfg_write(CfgMode, 64'(ModeHold));
    cfg_write(CfgVar, 64'd1);
    send_sample(16'sd50, -16'sd60, 12'd300);
    send_sample(16'sd52, -16'sd58, 12'd300);
    wait_idle();
  endtask

  // random configuration per phase, mostly hold with drifting positions
  task automatic test_random();
    logic signed [15:0] px, py;
    logic [63:0] k[4];
    int n;
    for (int ph = 0; ph < 9; ph++) begin
      for (int i = 0; i < 4; i++) begin
        if (ph == 0) k[i] = '1;
        else if ($urandom_range(0, 5) == 0) k[i] = {$urandom, $urandom};
        else k[i] = {16'($urandom_range(0, 2000)), 16'($urandom_range(0, 600)),
                     16'($urandom_range(0, 300)), 16'($urandom_range(0, 800))};
      end
      load_gains(k[0], k[1], k[2], k[3]);
      cfg_write(CfgTarget, 64'($urandom));
      cfg_write(CfgMode, ($urandom_range(0, 9) < 7) ? 64'(ModeHold) : 64'($urandom_range(0, 3)));
      cfg_write(CfgVar, 64'($urandom_range(0, 1)));
      cfg_write(CfgMinH, (ph == 1) ? 64'd4095 : (ph == 2) ? 64'd0 : 64'($urandom_range(0, 200)));
      no_gaps = (ph == 3);
      px = $signed(setpoint[15:0]);
      py = $signed(setpoint[31:16]);
      n = 50;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          px = 16'($urandom);
          py = 16'($urandom);
        end else begin
          px = px + 16'($signed(5'($urandom)));
          py = py + 16'($signed(5'($urandom)));
        end
        send_sample(px, py, ($urandom_range(0, 7) == 0) ? 12'($urandom) :
                    12'($urandom_range(0, 300)));
        if (ph == 4 && i == 25) begin
          // sender holds off until everything is back
          in_valid <= 1'b0;
          while (cmd_q.size() != 0) @(posedge clk_i);
        end else idle_gap();
      end
      wait_idle();
    end
  endtask

  // result check and receiver stalls
  always @(posedge clk_i) begin
    cmd_t exp_c;
    int r;
    if (rst_ni && out_valid && out_ready) begin
      n_results++;
      if (cmd_q.size() == 0) begin
        $error("result with nothing expected: pitch %0d roll %0d", pitch_cmd, roll_cmd);
        n_err++;
      end else begin
        exp_c = cmd_q.pop_front();
        if (pitch_cmd !== exp_c.pitch) begin
          $error("pitch_cmd expected %0d actual %0d", exp_c.pitch, pitch_cmd);
          n_err++;
        end
        if (roll_cmd !== exp_c.roll) begin
          $error("roll_cmd expected %0d actual %0d", exp_c.roll, roll_cmd);
          n_err++;
        end
      end
    end
    r = $urandom_range(0, 99);
    if (no_gaps) out_ready <= 1'b1;
    else if (r < 70) out_ready <= 1'b1;
    else if (r < 97) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 30) == 0);
  end

  // watchdog on cycles without any transaction
  int quiet;
  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    outer_k = '{default: '0};
    inner_k = '{default: '0};
    setpoint = '0;
    hold_mode = ModeFree;
    variant = 1'b0;
    min_h = 12'd40;
    outer_acc = '{default: 0};
    inner_acc = '{default: 0};
    last_err = '{default: 0};
    last_spd = '{default: 0};
    last_pos = '{default: 0};
    last_cmd = '{default: 0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_hold_extremes();
    test_modes();
    test_random();
    wait_idle();
    $display("covered %0d samples (%0d in closed loop), %0d results, %0d register writes",
             n_items, n_hold, n_results, n_cfg);
    if (n_err == 0 && cmd_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
